>>> rtl/lpcs_pkg.sv
package lpcs_pkg;

  localparam int PANEL_WIDTH  = 240;
  localparam int PANEL_HEIGHT = 320;

  localparam int CoordW  = 9;
  localparam int ColourW = 24;
  localparam int Rgb565W = 16;
  localparam int RotW    = 2;

  localparam logic [CoordW-1:0] PanelWMax = CoordW'(PANEL_WIDTH - 1);
  localparam logic [CoordW-1:0] PanelHMax = CoordW'(PANEL_HEIGHT - 1);

  localparam logic [7:0] CmdColumn = 8'h2A;
  localparam logic [7:0] CmdRow    = 8'h2B;
  localparam logic [7:0] CmdPixel  = 8'h2C;

  typedef enum logic [RotW-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  // Position of a byte within the full thirteen-byte pixel sequence.
  typedef enum logic [3:0] {
    STEP_COL_CMD = 4'd0,
    STEP_COL_HI0 = 4'd1,
    STEP_COL_LO0 = 4'd2,
    STEP_COL_HI1 = 4'd3,
    STEP_COL_LO1 = 4'd4,
    STEP_ROW_CMD = 4'd5,
    STEP_ROW_HI0 = 4'd6,
    STEP_ROW_LO0 = 4'd7,
    STEP_ROW_HI1 = 4'd8,
    STEP_ROW_LO1 = 4'd9,
    STEP_PIX_CMD = 4'd10,
    STEP_PIX_HI  = 4'd11,
    STEP_PIX_LO  = 4'd12
  } step_e;

  typedef struct packed {
    logic                send_col;
    logic                send_row;
    logic [CoordW-1:0]   px;
    logic [CoordW-1:0]   py;
    logic [Rgb565W-1:0]  rgb;
  } lpcs_job_t;

endpackage

>>> rtl/lpcs_pixel_if.sv
interface lpcs_pixel_if;
  logic        valid;
  logic        ready;
  logic [8:0]  pos_x;
  logic [8:0]  pos_y;
  logic [23:0] colour;

  modport source (output valid, output pos_x, output pos_y, output colour, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input colour, output ready);
endinterface

>>> rtl/lpcs_byte_if.sv
interface lpcs_byte_if;
  logic       valid;
  logic       ready;
  logic       dc;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output dc, output data_byte, output last, input ready);
  modport sink   (input valid, input dc, input data_byte, input last, output ready);
endinterface

>>> rtl/lpcs_cfg_if.sv
interface lpcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lcd_pixel_command_stream.sv
// Channel   Dir  Beat contents
// pix_i     in   pos_x, pos_y, colour (one pixel)
// cfg_i     in   data: rotation
// bytes_o   out  dc, data_byte, last (one byte of the panel stream)
//
// A pixel gives 3, 8 or 13 output beats, one per cycle unless bytes_o.ready
// stalls them, from the byte sequencer's output register. A taken pixel
// passes through the job register and then that output register.
// Reset clears the rotation and both window caches; the first pixel always
// sends both windows. A stalled output holds its beat; one pixel waits in the
// job register behind the sequencer, and pix_i.ready drops once both are full.
module lcd_pixel_command_stream (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpcs_pixel_if.sink pix_i,
  lpcs_cfg_if.sink   cfg_i,
  lpcs_byte_if.source bytes_o
);
  import lpcs_pkg::*;

  logic      job_valid;
  lpcs_job_t job;
  logic      job_take;

  assign cfg_i.ready = 1'b1;

  lpcs_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .pos_x_i     (pix_i.pos_x),
    .pos_y_i     (pix_i.pos_y),
    .colour_i    (pix_i.colour),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_take_i  (job_take)
  );

  lpcs_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .out_valid_o (bytes_o.valid),
    .out_ready_i (bytes_o.ready),
    .dc_o        (bytes_o.dc),
    .data_byte_o (bytes_o.data_byte),
    .last_o      (bytes_o.last)
  );

endmodule

>>> rtl/lpcs_xform.sv
module lpcs_xform (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pix_valid_i,
  output logic                pix_ready_o,
  input  logic [8:0]          pos_x_i,
  input  logic [8:0]          pos_y_i,
  input  logic [23:0]         colour_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_data_i,
  output logic                job_valid_o,
  output lpcs_pkg::lpcs_job_t job_o,
  input  logic                job_take_i
);
  import lpcs_pkg::*;

  rot_e              rot_q;
  logic              col_valid_q;
  logic [CoordW-1:0] col_q;
  logic              row_valid_q;
  logic [CoordW-1:0] row_q;
  logic              job_valid_q, job_valid_d;
  lpcs_job_t         job_q, job_d;
  logic              accept;
  logic [CoordW-1:0] px, py;

  assign pix_ready_o = !job_valid_q || job_take_i;
  assign accept      = pix_valid_i && pix_ready_o;

  always_comb begin
    unique case (rot_q)
      ROT_90: begin
        px = pos_y_i;
        py = PanelHMax - pos_x_i;
      end
      ROT_180: begin
        px = PanelWMax - pos_x_i;
        py = PanelHMax - pos_y_i;
      end
      ROT_270: begin
        px = PanelWMax - pos_y_i;
        py = pos_x_i;
      end
      default: begin
        px = pos_x_i;
        py = pos_y_i;
      end
    endcase
  end

  // The window cache is updated as each pixel is taken, so the flags in the
  // job already reflect every earlier pixel.
  always_comb begin
    job_d.send_col = !col_valid_q || (px != col_q);
    job_d.send_row = !row_valid_q || (py != row_q);
    job_d.px       = px;
    job_d.py       = py;
    job_d.rgb      = {colour_i[23:19], colour_i[15:10], colour_i[7:3]};
    job_valid_d    = accept || (job_valid_q && !job_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q       <= ROT_0;
      col_valid_q <= 1'b0;
      row_valid_q <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      if (cfg_valid_i) begin
        rot_q <= rot_e'(cfg_data_i);
      end
      if (accept) begin
        col_valid_q <= 1'b1;
        row_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
      col_q <= px;
      row_q <= py;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

>>> rtl/lpcs_serial.sv
module lpcs_serial (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  lpcs_pkg::lpcs_job_t job_i,
  output logic                job_take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                dc_o,
  output logic [7:0]          data_byte_o,
  output logic                last_o
);
  import lpcs_pkg::*;

  logic       act_q, act_d;
  lpcs_job_t  act_job_q;
  step_e      step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       dc_q, dc_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;

  logic       load_out;
  logic       src_valid;
  lpcs_job_t  src_job;
  step_e      start_step;
  step_e      src_step;

  assign load_out  = !out_valid_q || out_ready_i;
  assign src_valid = act_q || job_valid_i;
  assign src_job   = act_q ? act_job_q : job_i;

  always_comb begin
    priority if (job_i.send_col) begin
      start_step = STEP_COL_CMD;
    end else if (job_i.send_row) begin
      start_step = STEP_ROW_CMD;
    end else begin
      start_step = STEP_PIX_CMD;
    end
  end

  assign src_step   = act_q ? step_q : start_step;
  assign job_take_o = load_out && !act_q && job_valid_i;

  always_comb begin
    dc_d   = 1'b1;
    last_d = 1'b0;
    byte_d = 8'h00;
    step_d = step_e'(src_step + 4'd1);
    unique case (src_step)
      STEP_COL_CMD: begin
        dc_d   = 1'b0;
        byte_d = CmdColumn;
      end
      STEP_COL_HI0, STEP_COL_HI1: byte_d = 8'h00;
      STEP_COL_LO0: byte_d = src_job.px[7:0];
      STEP_COL_LO1: begin
        byte_d = src_job.px[7:0];
        step_d = src_job.send_row ? STEP_ROW_CMD : STEP_PIX_CMD;
      end
      STEP_ROW_CMD: begin
        dc_d   = 1'b0;
        byte_d = CmdRow;
      end
      STEP_ROW_HI0, STEP_ROW_HI1: byte_d = {7'd0, src_job.py[8]};
      STEP_ROW_LO0, STEP_ROW_LO1: byte_d = src_job.py[7:0];
      STEP_PIX_CMD: begin
        dc_d   = 1'b0;
        byte_d = CmdPixel;
      end
      STEP_PIX_HI: byte_d = src_job.rgb[15:8];
      STEP_PIX_LO: begin
        byte_d = src_job.rgb[7:0];
        last_d = 1'b1;
        step_d = STEP_COL_CMD;
      end
      default: begin
        byte_d = 8'h00;
        step_d = STEP_COL_CMD;
      end
    endcase
  end

  always_comb begin
    act_d       = act_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = src_valid;
      if (src_valid) begin
        act_d = !last_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= STEP_COL_CMD;
    end else begin
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
      if (load_out && src_valid) begin
        step_q <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out && src_valid) begin
      act_job_q <= src_job;
      dc_q      <= dc_d;
      byte_q    <= byte_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dc_o        = dc_q;
  assign data_byte_o = byte_q;
  assign last_o      = last_q;

endmodule

>>> tb/lcd_pixel_command_stream_tb.sv
module lcd_pixel_command_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpcs_pkg::*;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int TAIL_CYCLES      = 20;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES    = 5;
  localparam int PHASE_PIXELS     = 50;
  localparam int MAX_REPORTS      = 100;

  localparam logic DC_CMD  = 1'b0;
  localparam logic DC_DATA = 1'b1;

  typedef struct packed {
    logic       dc;
    logic [7:0] data;
    logic       last;
  } panel_beat_t;

  typedef struct {
    rot_e        rot;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [23:0] colour;
    int          beats;   // zero leaves the row to the predictor alone
    logic [15:0] rgb;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lpcs_pixel_if pixel_ch ();
  lpcs_cfg_if   rot_ch ();
  lpcs_byte_if  byte_ch ();

  lcd_pixel_command_stream DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pixel_ch),
    .cfg_i   (rot_ch),
    .bytes_o (byte_ch)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block's register and window caches.
  rot_e        rotation_model = ROT_0;
  logic        col_valid = 1'b0;
  logic [8:0]  col_cache = '0;
  logic        row_valid = 1'b0;
  logic [8:0]  row_cache = '0;

  panel_beat_t bytes_due[$];
  pixel_row_t  directed_rows [20];

  int          fail_count = 0;
  int          send_calm = 0;
  int          sink_calm = 0;
  logic        long_hold_req = 1'b0;

  // Per-pixel view of the output, used by the typed rows of the table.
  int          beats_in_pixel = 0;
  int          seen_beats = 0;
  logic [15:0] seen_rgb = '0;
  logic [7:0]  prev_byte = '0;

  // Mostly a random wait, now and then a run of back-to-back beats.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [8:0] pick_coord();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 9'd319 : 9'd0;
    end
    return 9'($urandom_range(0, 319));
  endfunction

  function automatic void predict_pixel_bytes(input logic [8:0] x, input logic [8:0] y,
                                              input logic [23:0] colour);
    logic [8:0]  px;
    logic [8:0]  py;
    logic [15:0] rgb;
    case (rotation_model)
      ROT_90: begin
        px = y;
        py = PanelHMax - x;
      end
      ROT_180: begin
        px = PanelWMax - x;
        py = PanelHMax - y;
      end
      ROT_270: begin
        px = PanelWMax - y;
        py = x;
      end
      default: begin
        px = x;
        py = y;
      end
    endcase
    rgb = {colour[23:19], colour[15:10], colour[7:3]};

    if (!col_valid || px != col_cache) begin
      bytes_due.push_back('{DC_CMD, CmdColumn, 1'b0});
      bytes_due.push_back('{DC_DATA, 8'h00, 1'b0});
      bytes_due.push_back('{DC_DATA, px[7:0], 1'b0});
      bytes_due.push_back('{DC_DATA, 8'h00, 1'b0});
      bytes_due.push_back('{DC_DATA, px[7:0], 1'b0});
      col_cache = px;
      col_valid = 1'b1;
    end
    if (!row_valid || py != row_cache) begin
      bytes_due.push_back('{DC_CMD, CmdRow, 1'b0});
      bytes_due.push_back('{DC_DATA, {7'b0, py[8]}, 1'b0});
      bytes_due.push_back('{DC_DATA, py[7:0], 1'b0});
      bytes_due.push_back('{DC_DATA, {7'b0, py[8]}, 1'b0});
      bytes_due.push_back('{DC_DATA, py[7:0], 1'b0});
      row_cache = py;
      row_valid = 1'b1;
    end
    bytes_due.push_back('{DC_CMD, CmdPixel, 1'b0});
    bytes_due.push_back('{DC_DATA, rgb[15:8], 1'b0});
    bytes_due.push_back('{DC_DATA, rgb[7:0], 1'b1});
  endfunction

  // Everything the block takes or gives is seen here at the rising edge.
  always @(posedge clk_i) begin
    panel_beat_t want;
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (bytes_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: unexpected beat dc=%0b data=%02h last=%0b", $time,
                     byte_ch.dc, byte_ch.data_byte, byte_ch.last);
          end
        end else begin
          want = bytes_due.pop_front();
          if (byte_ch.dc !== want.dc || byte_ch.data_byte !== want.data ||
              byte_ch.last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: beat mismatch expected dc=%0b data=%02h last=%0b, got dc=%0b data=%02h last=%0b",
                       $time, want.dc, want.data, want.last,
                       byte_ch.dc, byte_ch.data_byte, byte_ch.last);
            end
          end
        end
        beats_in_pixel++;
        if (byte_ch.last) begin
          seen_beats = beats_in_pixel;
          seen_rgb = {prev_byte, byte_ch.data_byte};
          beats_in_pixel = 0;
        end
        prev_byte = byte_ch.data_byte;
      end
      if (rot_ch.valid && rot_ch.ready) begin
        rotation_model = rot_e'(rot_ch.data);
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        predict_pixel_bytes(pixel_ch.pos_x, pixel_ch.pos_y, pixel_ch.colour);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic drive_pixel(input logic [8:0] x, input logic [8:0] y,
                             input logic [23:0] colour);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pixel_ch.valid  <= 1'b1;
    pixel_ch.pos_x  <= x;
    pixel_ch.pos_y  <= y;
    pixel_ch.colour <= colour;
    @(posedge clk_i);
    while (!pixel_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_rotation(input rot_e rot);
    rot_ch.valid <= 1'b1;
    rot_ch.data  <= rot;
    @(posedge clk_i);
    while (!rot_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    rot_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (bytes_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin : byte_sink
    int stall;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD_CYCLES;
      end else begin
        stall = draw_wait(sink_calm);
      end
      if (stall > 0) begin
        byte_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      byte_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!byte_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d beats still due", $time, cycles,
             bytes_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    rot_e        cur_rot;
    pixel_row_t  row;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [23:0] colour;
    int          sel;

    pixel_ch.valid  = 1'b0;
    pixel_ch.pos_x  = '0;
    pixel_ch.pos_y  = '0;
    pixel_ch.colour = '0;
    rot_ch.valid    = 1'b0;
    rot_ch.data     = '0;
    byte_ch.ready   = 1'b0;
    cur_rot = ROT_0;

    // The first eight rows start from reset and can be read off by hand.
    directed_rows = '{
      '{ROT_0,   9'd0,   9'd0,   24'h000000, 13, 16'h0000},
      '{ROT_0,   9'd0,   9'd0,   24'hFFFFFF, 3,  16'hFFFF},
      '{ROT_0,   9'd0,   9'd0,   24'hF80000, 3,  16'hF800},
      '{ROT_0,   9'd0,   9'd0,   24'h00FC00, 3,  16'h07E0},
      '{ROT_0,   9'd0,   9'd0,   24'h0000F8, 3,  16'h001F},
      '{ROT_0,   9'd0,   9'd0,   24'h070307, 3,  16'h0000},
      '{ROT_0,   9'd319, 9'd0,   24'hFFFFFF, 8,  16'hFFFF},
      '{ROT_0,   9'd319, 9'd319, 24'h000000, 8,  16'h0000},
      '{ROT_0,   9'd255, 9'd256, 24'h123456, 0,  16'h0000},
      '{ROT_0,   9'd256, 9'd255, 24'hA5C3E7, 0,  16'h0000},
      '{ROT_0,   9'd0,   9'd255, 24'h5A3C18, 0,  16'h0000},
      '{ROT_90,  9'd0,   9'd0,   24'h808080, 0,  16'h0000},
      '{ROT_90,  9'd319, 9'd319, 24'h7F7F7F, 0,  16'h0000},
      '{ROT_180, 9'd0,   9'd0,   24'hC0FFEE, 0,  16'h0000},
      '{ROT_180, 9'd319, 9'd319, 24'h0F1E2D, 0,  16'h0000},
      '{ROT_180, 9'd240, 9'd0,   24'hE1D2C3, 0,  16'h0000},
      '{ROT_270, 9'd0,   9'd0,   24'h3C5A78, 0,  16'h0000},
      '{ROT_270, 9'd319, 9'd319, 24'h96B4D2, 0,  16'h0000},
      '{ROT_270, 9'd319, 9'd100, 24'h010203, 0,  16'h0000},
      '{ROT_0,   9'd5,   9'd5,   24'hFEDCBA, 0,  16'h0000}
    };

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.rot != cur_rot) begin
        pixel_ch.valid <= 1'b0;
        wait_drained();
        write_rotation(row.rot);
        cur_rot = row.rot;
      end
      drive_pixel(row.x, row.y, row.colour);
      if (row.beats != 0) begin
        pixel_ch.valid <= 1'b0;
        wait_drained();
        if (seen_beats != row.beats || seen_rgb != row.rgb) begin
          fail_count++;
          $display("%0t: pixel %0d expected %0d beats rgb565=%04h, got %0d beats rgb565=%04h",
                   $time, i, row.beats, row.rgb, seen_beats, seen_rgb);
        end
      end
    end

    // Runs along a row or a column hit the window caches, so most pixels
    // repeat one or both coordinates of the one before.
    x = 9'd5;
    y = 9'd5;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pixel_ch.valid <= 1'b0;
      wait_drained();
      cur_rot = rot_e'($urandom_range(0, 3));
      write_rotation(cur_rot);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (phase == 1 && n == 4) begin
          long_hold_req = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (sel >= 35 && sel < 60) begin
          x = pick_coord();
        end else if (sel >= 60 && sel < 75) begin
          y = pick_coord();
        end else if (sel >= 75) begin
          x = pick_coord();
          y = pick_coord();
        end
        colour = 24'($urandom);
        drive_pixel(x, y, colour);
      end
    end

    pixel_ch.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
